// ===== rtl/cqu_pkg.sv =====
// Shared constants, codes and types for the per-class queue block.
// Used by cqu_meta_store and the top level under rtl; depends on nothing else.
`default_nettype none
package cqu_pkg;

	localparam int NUM_CLASSES = 32;
	localparam int QUEUE_DEPTH = 8;
	localparam int ID_BITS     = 16;

	// Fixed field widths of the ports.
	localparam int FIELD_ID_W  = 16;
	localparam int FIELD_CLS_W = 5;
	localparam int FIELD_CNT_W = 4;
	localparam int LIMIT_W     = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

	localparam int CLASS_AW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W      = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
	localparam int ENTRY_AW   = CLASS_AW + SLOT_W;
	localparam int ENTRY_SLOTS = 1 << ENTRY_AW;
	localparam int STORE_ID_W = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
	localparam int ENTRY_W    = STORE_ID_W + 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_POP = 1'b1;

	localparam logic [1:0] RES_ADDED    = 2'd0;
	localparam logic [1:0] RES_REJECTED = 2'd1;
	localparam logic [1:0] RES_POPPED   = 2'd2;
	localparam logic [1:0] RES_EMPTY    = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [SLOT_W-1:0] head;
	} meta_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FETCH
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/cqu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module cqu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// Read data holds while no read is issued.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cqu_meta_store.sv =====
// Per-class count and head store: a RAM plus one valid bit per class.
// Depends on cqu_pkg and cqu_ram.
`default_nettype none
module cqu_meta_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [cqu_pkg::CLASS_AW-1:0] rd_cls,
	output cqu_pkg::meta_t                     rd_meta,
	input  wire logic                          wr_en,
	input  wire logic [cqu_pkg::CLASS_AW-1:0] wr_cls,
	input  wire cqu_pkg::meta_t                wr_meta
);

	logic [cqu_pkg::NUM_CLASSES-1:0] vld_q;
	logic                            vld_s1;
	cqu_pkg::meta_t                  ram_rdata;

	cqu_ram #(
		.WIDTH($bits(cqu_pkg::meta_t)),
		.DEPTH(cqu_pkg::NUM_CLASSES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_cls),
		.wdata(wr_meta),
		.re   (rd_en),
		.raddr(rd_cls),
		.rdata(ram_rdata)
	);

	// A class that was never written reads as an empty queue with head zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_cls] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_cls];
			end
		end
	end

	assign rd_meta = vld_s1 ? ram_rdata : '0;

endmodule
`default_nettype wire

// ===== rtl/class_queue_urgent_front_insert.sv =====
// Top level of the per-class bounded queues with urgent front insertion.
// Depends on cqu_pkg, cqu_ram and cqu_meta_store.
`default_nettype none
// One transaction is handled at a time. An add loads its result into the output register
// from the lookup state and a pop from the fetch state: the lookup state has the class's count
// and head from the class memory, and a pop then reads the front entry from the entry memory.
// The next transaction is accepted in the cycle after the result is loaded. A result
// waiting in the output register lets the next transaction start; that transaction
// finishes once the register is free. Counts reset to zero through per-class valid bits,
// so no clearing pass is needed after reset. The queue limit is taken as the smaller of
// the register value and the ring depth.
module class_queue_urgent_front_insert (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [3:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [4:0]  queue_index,
	input  wire logic [15:0] entry_id,
	input  wire logic        urgent,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_code,
	output logic [15:0]      out_id,
	output logic             out_urgent,
	output logic [3:0]       out_count
);

	cqu_pkg::state_t state_q, state_d;

	logic [cqu_pkg::LIMIT_W-1:0]     limit_q;
	logic                            func_q;
	logic [cqu_pkg::FIELD_CLS_W-1:0] cls_q;
	logic [cqu_pkg::STORE_ID_W-1:0]  id_q;
	logic                            urg_q;
	logic [cqu_pkg::CNT_W-1:0]       pop_cnt_q;

	logic                            out_valid_q;
	logic [1:0]                      code_q;
	logic [cqu_pkg::STORE_ID_W-1:0]  oid_q;
	logic                            ourg_q;
	logic [cqu_pkg::CNT_W-1:0]       ocnt_q;

	logic                            accept;
	logic                            out_free;
	logic [cqu_pkg::CLASS_AW-1:0]    cls_addr;
	cqu_pkg::meta_t                  meta_rd;
	cqu_pkg::meta_t                  meta_wr;
	logic                            meta_we;
	logic                            entry_we;
	logic                            entry_re;
	logic [cqu_pkg::ENTRY_AW-1:0]    entry_waddr;
	logic [cqu_pkg::ENTRY_AW-1:0]    entry_raddr;
	logic [cqu_pkg::ENTRY_W-1:0]     entry_rdata;

	logic                            out_load;
	logic [1:0]                      load_code;
	logic [cqu_pkg::STORE_ID_W-1:0]  load_id;
	logic                            load_urg;
	logic [cqu_pkg::CNT_W-1:0]       load_cnt;

	logic                            cls_bad;
	logic                            full;
	logic [cqu_pkg::SLOT_W-1:0]      head_prev;
	logic [cqu_pkg::SLOT_W-1:0]      head_next;
	logic [cqu_pkg::SUM_W-1:0]       tail_sum;
	logic [cqu_pkg::SLOT_W-1:0]      tail;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cls_addr = cqu_pkg::CLASS_AW'(cls_q);

	cqu_meta_store u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_cls (cqu_pkg::CLASS_AW'(queue_index)),
		.rd_meta(meta_rd),
		.wr_en  (meta_we),
		.wr_cls (cls_addr),
		.wr_meta(meta_wr)
	);

	cqu_ram #(
		.WIDTH(cqu_pkg::ENTRY_W),
		.DEPTH(cqu_pkg::ENTRY_SLOTS)
	) u_entries (
		.clk  (clk),
		.we   (entry_we),
		.waddr(entry_waddr),
		.wdata({urg_q, id_q}),
		.re   (entry_re),
		.raddr(entry_raddr),
		.rdata(entry_rdata)
	);

	// Ring arithmetic on the head slot; the sum stays below twice the depth.
	always_comb begin
		cls_bad   = int'(cls_q) >= cqu_pkg::NUM_CLASSES;
		full      = (int'(meta_rd.cnt) >= int'(limit_q)) ||
		            (int'(meta_rd.cnt) >= cqu_pkg::QUEUE_DEPTH);
		head_prev = (meta_rd.head == '0) ? cqu_pkg::LAST_SLOT
		                                 : meta_rd.head - cqu_pkg::SLOT_W'(1);
		head_next = (meta_rd.head == cqu_pkg::LAST_SLOT) ? '0
		                                                 : meta_rd.head + cqu_pkg::SLOT_W'(1);
		tail_sum  = cqu_pkg::SUM_W'(meta_rd.head) + cqu_pkg::SUM_W'(meta_rd.cnt);
		tail      = (tail_sum >= cqu_pkg::SUM_W'(cqu_pkg::QUEUE_DEPTH))
		          ? cqu_pkg::SLOT_W'(tail_sum - cqu_pkg::SUM_W'(cqu_pkg::QUEUE_DEPTH))
		          : cqu_pkg::SLOT_W'(tail_sum);
	end

	assign entry_waddr = {cls_addr, urg_q ? head_prev : tail};
	assign entry_raddr = {cls_addr, meta_rd.head};

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		meta_we   = 1'b0;
		meta_wr   = meta_rd;
		entry_we  = 1'b0;
		entry_re  = 1'b0;
		out_load  = 1'b0;
		load_code = cqu_pkg::RES_REJECTED;
		load_id   = '0;
		load_urg  = 1'b0;
		load_cnt  = '0;

		case (state_q)
			cqu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = cqu_pkg::ST_LOOKUP;
				end
			end
			cqu_pkg::ST_LOOKUP: begin
				if (cls_bad) begin
					load_code = (func_q == cqu_pkg::FUNC_POP) ? cqu_pkg::RES_EMPTY
					                                          : cqu_pkg::RES_REJECTED;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = cqu_pkg::ST_IDLE;
					end
				end else if (func_q == cqu_pkg::FUNC_ADD) begin
					load_cnt = meta_rd.cnt;
					if (full) begin
						load_code = cqu_pkg::RES_REJECTED;
					end else begin
						load_code = cqu_pkg::RES_ADDED;
						load_cnt  = meta_rd.cnt + cqu_pkg::CNT_W'(1);
					end
					if (out_free) begin
						out_load = 1'b1;
						state_d  = cqu_pkg::ST_IDLE;
						if (!full) begin
							entry_we     = 1'b1;
							meta_we      = 1'b1;
							meta_wr.cnt  = load_cnt;
							meta_wr.head = urg_q ? head_prev : meta_rd.head;
						end
					end
				end else if (meta_rd.cnt == '0) begin
					load_code = cqu_pkg::RES_EMPTY;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = cqu_pkg::ST_IDLE;
					end
				end else begin
					// The class state is updated now; the entry read completes next cycle.
					entry_re     = 1'b1;
					meta_we      = 1'b1;
					meta_wr.cnt  = meta_rd.cnt - cqu_pkg::CNT_W'(1);
					meta_wr.head = head_next;
					state_d      = cqu_pkg::ST_FETCH;
				end
			end
			cqu_pkg::ST_FETCH: begin
				load_code = cqu_pkg::RES_POPPED;
				load_id   = entry_rdata[cqu_pkg::STORE_ID_W-1:0];
				load_urg  = entry_rdata[cqu_pkg::ENTRY_W-1];
				load_cnt  = pop_cnt_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = cqu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cqu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cqu_pkg::ST_IDLE;
			limit_q     <= cqu_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			cls_q  <= queue_index;
			id_q   <= entry_id[cqu_pkg::STORE_ID_W-1:0];
			urg_q  <= urgent;
		end
		if (entry_re) begin
			pop_cnt_q <= meta_wr.cnt;
		end
		if (out_load) begin
			code_q <= load_code;
			oid_q  <= load_id;
			ourg_q <= load_urg;
			ocnt_q <= load_cnt;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_code = code_q;
	assign out_id      = cqu_pkg::FIELD_ID_W'(oid_q);
	assign out_urgent  = ourg_q;
	assign out_count   = cqu_pkg::FIELD_CNT_W'(ocnt_q);

endmodule
`default_nettype wire
